// File: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ialu_pkg.sv
package ialu_pkg;

   // Default datapath width and the fixed stream field widths
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int CMD_W          = 3;
   // command + operand_a + operand_b, padded to whole bytes
   localparam int REQ_TDATA_W    = 72;
   // result + divide_error, padded to whole bytes
   localparam int RSP_TDATA_W    = 40;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_MOD = 3'd4,
      CMD_GCD = 3'd5,
      CMD_LCM = 3'd6
   } cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_GCD_TEST,
      S_NEG_N,
      S_NEG_D,
      S_DIV_STEP,
      S_DIV_FIX,
      S_MUL_STEP,
      S_DONE
   } state_type;

endpackage

// File: design/ialu_addsub.sv
// Shared add/subtract unit: sum = x + y, or x - y when sub is set.
module ialu_addsub #(
   parameter int WIDTH = ialu_pkg::DATA_WIDTH_DEF + 1
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   input  logic             sub,
   output logic [WIDTH-1:0] sum
);
   import ialu_pkg::*;

   // Invert and carry in one for subtraction
   assign sum = x + (y ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

// File: design/integer_alu_gcd_lcm_top.sv
// Add, sub, unused commands, and div or mod by zero finish at dispatch; mul runs shift-add
// steps; div and mod take magnitudes, run restoring steps and fix the sign; gcd runs one such
// division per Euclid step; lcm then divides a by the gcd and multiplies by b (W = DATA_WIDTH).
// One item at a time: req_tready is high only when idle, so the next transfer comes at best
// as rsp_tvalid rises. The single (W+1)-bit adder makes one quotient or product bit per cycle.
// Reset is synchronous: it clears the sequencer and the output valid, no clearing pass.
module integer_alu_gcd_lcm_top #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[2:0], operand_a[34:3], operand_b[66:35], zero pad
   input  logic [ialu_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result[31:0], divide_error[32], zero pad
   output logic [ialu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ialu_pkg::*;

   localparam int W        = DATA_WIDTH;
   localparam int CW       = $clog2(W);
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   state_type      state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [W-1:0]   opa_ff, opa_in, opb_ff, opb_in;
   logic [W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [W-1:0]   quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           negq_ff, negq_in, negr_ff, negr_in;
   logic           lcm_fin_ff, lcm_fin_in;
   logic [W-1:0]   res_ff, res_in;
   logic           err_ff, err_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]   out_res_ff, out_res_in;
   logic           out_err_ff, out_err_in;

   logic [W:0]     ux, uy, usum;
   logic           usub;
   logic [W-1:0]   a_ld, b_ld;
   logic [FIELD_W-1:0] req_a, req_b, res_out;
   logic           div_go;
   logic [W-1:0]   div_n, div_d;
   logic [W:0]     rem_sh;
   logic           want_q, want_neg;
   logic [W-1:0]   fix_val;

   assign req_a = req_tdata[CMD_W +: FIELD_W];
   assign req_b = req_tdata[CMD_W + FIELD_W +: FIELD_W];

   // Sign-extend or truncate operands to the datapath width; truncate or zero-extend the result to the field width
   if (W > FIELD_W) begin : g_wide
      assign a_ld    = {{(W - FIELD_W){req_a[FIELD_W-1]}}, req_a};
      assign b_ld    = {{(W - FIELD_W){req_b[FIELD_W-1]}}, req_b};
      assign res_out = out_res_ff[FIELD_W-1:0];
   end else if (W == FIELD_W) begin : g_same
      assign a_ld    = req_a;
      assign b_ld    = req_b;
      assign res_out = out_res_ff;
   end else begin : g_narrow
      assign a_ld    = req_a[W-1:0];
      assign b_ld    = req_b[W-1:0];
      assign res_out = {{(FIELD_W - W){1'b0}}, out_res_ff};
   end

   ialu_addsub #(.WIDTH(W + 1)) u_addsub (
      .x   (ux),
      .y   (uy),
      .sub (usub),
      .sum (usum)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - FIELD_W - 1){1'b0}}, out_err_ff, res_out};

   // Shifted partial remainder and the sign fix-up selection
   assign rem_sh   = {rem_ff, quo_ff[W-1]};
   assign want_q   = (cmd_ff == CMD_DIV) || lcm_fin_ff;
   assign fix_val  = want_q ? quo_ff : rem_ff;
   assign want_neg = want_q ? negq_ff : negr_ff;

   // Sequencer: next state and datapath register loads
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      negq_in      = negq_ff;
      negr_in      = negr_ff;
      lcm_fin_in   = lcm_fin_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_res_in   = out_res_ff;
      out_err_in   = out_err_ff;
      ux           = '0;
      uy           = '0;
      usub         = 1'b0;
      div_go       = 1'b0;
      div_n        = '0;
      div_d        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = cmd_type'(req_tdata[CMD_W-1:0]);
               opa_in     = a_ld;
               opb_in     = b_ld;
               lcm_fin_in = 1'b0;
               err_in     = 1'b0;
               res_in     = '0;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (cmd_ff)
               CMD_ADD, CMD_SUB: begin
                  ux       = {1'b0, opa_ff};
                  uy       = {1'b0, opb_ff};
                  usub     = (cmd_ff == CMD_SUB);
                  res_in   = usum[W-1:0];
                  state_in = S_DONE;
               end
               CMD_MUL: begin
                  // accumulator in rem, multiplicand in dvs, multiplier in quo
                  rem_in   = '0;
                  dvs_in   = opa_ff;
                  quo_in   = opb_ff;
                  cnt_in   = '0;
                  state_in = S_MUL_STEP;
               end
               CMD_DIV, CMD_MOD: begin
                  if (opb_ff == '0) begin
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     div_go = 1'b1;
                     div_n  = opa_ff;
                     div_d  = opb_ff;
                  end
               end
               CMD_GCD, CMD_LCM: begin
                  x_in     = opa_ff;
                  y_in     = opb_ff;
                  state_in = S_GCD_TEST;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_GCD_TEST: begin
            priority if (y_ff != '0) begin
               // next Euclid step: remainder of x by y
               div_go = 1'b1;
               div_n  = x_ff;
               div_d  = y_ff;
            end else if (cmd_ff == CMD_GCD) begin
               res_in   = x_ff;
               state_in = S_DONE;
            end else if (x_ff == '0) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               // lcm: divide a by the gcd, then multiply by b
               lcm_fin_in = 1'b1;
               div_go     = 1'b1;
               div_n      = opa_ff;
               div_d      = x_ff;
            end
         end
         S_NEG_N: begin
            // take the magnitude of the dividend
            uy       = {1'b0, quo_ff};
            usub     = 1'b1;
            if (quo_ff[W-1]) quo_in = usum[W-1:0];
            state_in = S_NEG_D;
         end
         S_NEG_D: begin
            // take the magnitude of the divisor
            uy       = {1'b0, dvs_ff};
            usub     = 1'b1;
            if (dvs_ff[W-1]) dvs_in = usum[W-1:0];
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            // restoring division, one quotient bit per cycle
            ux   = rem_sh;
            uy   = {1'b0, dvs_ff};
            usub = 1'b1;
            if (!usum[W]) begin
               rem_in = usum[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[W-1:0];
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = S_DIV_FIX;
         end
         S_DIV_FIX: begin
            // apply the sign to quotient or remainder
            if (want_neg) begin
               uy   = {1'b0, fix_val};
               usub = 1'b1;
            end else begin
               ux = {1'b0, fix_val};
            end
            priority if (lcm_fin_ff) begin
               rem_in   = '0;
               dvs_in   = usum[W-1:0];
               quo_in   = opb_ff;
               cnt_in   = '0;
               state_in = S_MUL_STEP;
            end else if (cmd_ff == CMD_DIV || cmd_ff == CMD_MOD) begin
               res_in   = usum[W-1:0];
               state_in = S_DONE;
            end else begin
               x_in     = y_ff;
               y_in     = usum[W-1:0];
               state_in = S_GCD_TEST;
            end
         end
         S_MUL_STEP: begin
            // shift-add multiply, low W bits of the product
            ux     = {1'b0, rem_ff};
            uy     = quo_ff[0] ? {1'b0, dvs_ff} : '0;
            rem_in = usum[W-1:0];
            dvs_in = {dvs_ff[W-2:0], 1'b0};
            quo_in = {1'b0, quo_ff[W-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               res_in   = usum[W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_res_in   = res_ff;
               out_err_in   = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Start a signed division of div_n by div_d
      if (div_go) begin
         quo_in   = div_n;
         dvs_in   = div_d;
         rem_in   = '0;
         cnt_in   = '0;
         negq_in  = div_n[W-1] ^ div_d[W-1];
         negr_in  = div_n[W-1];
         state_in = S_NEG_N;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      negq_ff    <= negq_in;
      negr_ff    <= negr_in;
      lcm_fin_ff <= lcm_fin_in;
      res_ff     <= res_in;
      err_ff     <= err_in;
      out_res_ff <= out_res_in;
      out_err_ff <= out_err_in;
   end

endmodule

// File: design/ialu_checker.sv
`include "assert_macros.svh"

// Port-level checks on the ALU stream interface
module ialu_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ialu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ialu_pkg::*;

   logic rsp_stall;
   logic req_xfer;
   logic err_nonzero;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign req_xfer    = req_tvalid && req_tready;
   assign err_nonzero = rsp_tdata[FIELD_W] && (rsp_tdata[FIELD_W-1:0] != '0);

   // A stalled result holds its payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_stall |=> $stable(rsp_tdata), "rsp_tdata changed")

   // An error result always carries zero
   `ASSERT_CLK(a_err_zero, clock, reset, rsp_tvalid |-> !err_nonzero, "error result not zero")

   // The block goes busy right after taking an item
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_xfer |=> !req_tready, "ready after a transfer")

   // Reset leaves the block idle with no result pending
   `ASSERT_NR(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind integer_alu_gcd_lcm_top ialu_checker u_ialu_checker (.*);
